// File: sv/bals_pkg.sv
// Shared types, widths and constants of the Bezier arc-length sampler.
// Used by bezier_arc_length_sampler and the testbench; depends on nothing.
package bals_pkg;

    // Curve sampling
    localparam int SEGMENTS   = 128;
    localparam int MAX_POINTS = 64;
    localparam int SEG_W      = $clog2(SEGMENTS + 1);
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 6;

    // Fixed-point formats
    localparam int COORD_W  = 16;
    localparam int T_W      = 17;
    localparam int T_ONE    = 65536;
    localparam int T_FRAC   = 16;
    localparam int LEN_W    = 20;
    localparam int LEN_MAX  = (1 << LEN_W) - 1;
    localparam int SP_MIN   = 16;

    // Shared multiplier and accumulators
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int W_W      = 49;
    localparam int W_LO_W   = 25;
    localparam int ACC_W    = 64;
    localparam int RND_POS  = 48;

    // Arc-length mapping
    localparam int TGT_W    = LEN_W + IDX_W;
    localparam int DD_W     = LEN_W + IDX_W;
    localparam int KDD_W    = DD_W + SEG_W;
    localparam int DIV_W    = DD_W + SEG_W + T_FRAC + 2;
    localparam int QUO_W    = 17;
    localparam int DCNT_W   = $clog2(QUO_W);
    localparam int SQ_W     = 34;
    localparam int ROOT_W   = 18;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CLIPPED = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_INVALID, S_CT_SETUP, S_DIV,
        S_EV_PRE, S_EV_MAC, S_EV_FIN, S_EMIT,
        S_TB_INIT, S_TB_SQ, S_SQRT, S_TB_ACC, S_LEN,
        S_MT_TGT, S_BS_CHK, S_BS_WAIT, S_BS_CMP,
        S_K_RD, S_K_MUL, S_K_CHK, S_K1_WAIT, S_DIFF, S_KDD, S_MT_DIV
    } state_t;

    typedef enum logic [1:0] {
        PH_COUNT, PH_TABLE, PH_LEN, PH_SPACE
    } phase_t;

    // t of table sample k, rounded to nearest
    function automatic logic [T_W-1:0] seg_t(input logic [SEG_W-1:0] k);
        logic [31:0] v;
        v = 32'(k) * 32'(T_ONE) + 32'(SEGMENTS / 2);
        return T_W'(v / SEGMENTS);
    endfunction

endpackage

// File: sv/bals_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bals_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 129
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/bezier_arc_length_sampler.sv
// Top level of the cubic Bezier sampler: control sequencer and datapath.
// Depends on bals_pkg and bals_ram (cumulative length table).
//
// One request at a time: a transfer happens when start is high and busy is low, and busy
// stays high until the last point of the run has been issued. Results appear one per
// strobe cycle and cannot be held off. Every point runs through one shared 33x18
// multiplier. Count mode finds the t of each point by division, then evaluates the
// curve. Spacing mode first builds the length table over 128 segments, each by an
// evaluation, two squares, a square root and an accumulate, then divides the length;
// it then handles each point by the table search through the registered read port of
// the table RAM, the interpolation divide where needed and the evaluation. A count
// below two or a spacing below 16 is answered with a single result through S_CHECK
// and S_INVALID; a spacing that gives fewer than two points is answered the same way
// once the table is built.
module bezier_arc_length_sampler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic signed [15:0] p0_x,
    input  logic signed [15:0] p0_y,
    input  logic signed [15:0] p1_x,
    input  logic signed [15:0] p1_y,
    input  logic signed [15:0] p2_x,
    input  logic signed [15:0] p2_y,
    input  logic signed [15:0] p3_x,
    input  logic signed [15:0] p3_y,
    input  logic [6:0]  point_count,
    input  logic [15:0] spacing,
    output logic        strobe,
    output logic signed [15:0] point_x,
    output logic signed [15:0] point_y,
    output logic [5:0]  point_index,
    output logic        last,
    output logic [1:0]  status
);

    bals_pkg::state_t state_reg, state_next;
    bals_pkg::phase_t phase_reg;

    // request
    logic                         action_reg;
    logic [bals_pkg::CNT_W-1:0]   pc_reg;
    logic [15:0]                  sp_reg;
    logic [bals_pkg::COORD_W-1:0] bx_reg [4];
    logic [bals_pkg::COORD_W-1:0] by_reg [4];

    // run control
    logic [bals_pkg::IDX_W-1:0]   d_reg;
    logic [bals_pkg::IDX_W-1:0]   pt_reg;
    logic                         clip_reg;

    // evaluation
    logic [bals_pkg::T_W-1:0]     t_reg;
    logic [bals_pkg::T_W-1:0]     u_val;
    logic [2:0]                   ev_sub_reg;
    logic [1:0]                   ev_k_reg;
    logic [bals_pkg::MUL_A_W-1:0] uu_reg, tt_reg, ut_reg;
    logic [bals_pkg::W_W-1:0]     w_reg;
    logic [bals_pkg::ACC_W-1:0]   ax_reg, ay_reg, ax_rnd, ay_rnd;
    logic [bals_pkg::COORD_W-1:0] cx_reg, cy_reg, px_reg, py_reg;

    // table build
    logic [bals_pkg::SEG_W-1:0]   tb_i_reg;
    logic [bals_pkg::LEN_W-1:0]   acc_reg;
    logic [bals_pkg::COORD_W-1:0] dx_val, dy_val;
    logic [bals_pkg::SQ_W-1:0]    sqv_reg, sq_x_reg, sq_r_reg, sq_bit_reg, sq_trial;
    logic [bals_pkg::ROOT_W-1:0]  root_val;
    logic [bals_pkg::LEN_W:0]     acc_sum;
    logic [bals_pkg::LEN_W-1:0]   acc_sat;

    // divider
    logic [bals_pkg::DIV_W-1:0]   dv_rem_reg, dv_sh_reg;
    logic [bals_pkg::QUO_W-1:0]   dv_q_reg, q_next;
    logic [bals_pkg::DCNT_W-1:0]  dv_cnt_reg;
    logic                         dv_ge;

    // arc-length mapping
    logic [bals_pkg::TGT_W-1:0]   target_reg, ekd_reg, rem_reg;
    logic [bals_pkg::SEG_W-1:0]   lo_reg, hi_reg, k_reg;
    logic [bals_pkg::SEG_W:0]     mid_sum;
    logic                         kdec_reg;
    logic [bals_pkg::LEN_W-1:0]   ek_reg, diff_reg;
    logic [bals_pkg::DD_W-1:0]    dd_reg;
    logic [bals_pkg::KDD_W-1:0]   kdd_reg;

    // shared multiplier
    logic [bals_pkg::MUL_A_W-1:0] mul_a;
    logic [bals_pkg::MUL_B_W-1:0] mul_b;
    logic [bals_pkg::PROD_W-1:0]  prod;

    // table memory
    logic                         ram_we, ram_re;
    logic [bals_pkg::SEG_W-1:0]   ram_waddr, ram_raddr;
    logic [bals_pkg::LEN_W-1:0]   ram_wdata, ram_rdata;

    logic                         strobe_reg;
    logic [bals_pkg::COORD_W-1:0] out_x_reg, out_y_reg;
    logic [bals_pkg::IDX_W-1:0]   out_idx_reg;
    logic                         out_last_reg;
    logic [1:0]                   out_st_reg;

    bals_ram #(
        .WIDTH (bals_pkg::LEN_W),
        .DEPTH (bals_pkg::SEGMENTS + 1)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // datapath helpers
    assign u_val   = bals_pkg::T_W'(bals_pkg::T_ONE) - t_reg;
    assign prod    = bals_pkg::PROD_W'(mul_a) * bals_pkg::PROD_W'(mul_b);
    assign ax_rnd  = ax_reg + (bals_pkg::ACC_W'(1) << (bals_pkg::RND_POS - 1));
    assign ay_rnd  = ay_reg + (bals_pkg::ACC_W'(1) << (bals_pkg::RND_POS - 1));
    assign dx_val  = (cx_reg > px_reg) ? cx_reg - px_reg : px_reg - cx_reg;
    assign dy_val  = (cy_reg > py_reg) ? cy_reg - py_reg : py_reg - cy_reg;
    assign sq_trial = sq_r_reg + sq_bit_reg;
    assign root_val = bals_pkg::ROOT_W'(sq_r_reg)
                    + bals_pkg::ROOT_W'(sq_x_reg > sq_r_reg);
    assign acc_sum  = (bals_pkg::LEN_W+1)'(acc_reg) + (bals_pkg::LEN_W+1)'(root_val);
    assign acc_sat  = (acc_sum > (bals_pkg::LEN_W+1)'(bals_pkg::LEN_MAX))
                    ? bals_pkg::LEN_W'(bals_pkg::LEN_MAX) : acc_sum[bals_pkg::LEN_W-1:0];
    assign dv_ge    = dv_rem_reg >= dv_sh_reg;
    assign q_next   = {dv_q_reg[bals_pkg::QUO_W-2:0], dv_ge};
    assign mid_sum  = (bals_pkg::SEG_W+1)'(lo_reg) + (bals_pkg::SEG_W+1)'(hi_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bals_pkg::S_IDLE:
                if (start)
                begin
                    state_next = bals_pkg::S_CHECK;
                end
            bals_pkg::S_CHECK:
                if (!action_reg)
                begin
                    state_next = (pc_reg < 2) ? bals_pkg::S_INVALID : bals_pkg::S_CT_SETUP;
                end
                else
                begin
                    state_next = (sp_reg < 16'(bals_pkg::SP_MIN)) ? bals_pkg::S_INVALID
                                                                 : bals_pkg::S_TB_INIT;
                end
            bals_pkg::S_INVALID:  state_next = bals_pkg::S_IDLE;
            bals_pkg::S_CT_SETUP: state_next = bals_pkg::S_DIV;
            bals_pkg::S_DIV:
                if (dv_cnt_reg == '0)
                begin
                    if (phase_reg == bals_pkg::PH_LEN)
                    begin
                        state_next = (q_next < 2) ? bals_pkg::S_INVALID : bals_pkg::S_MT_TGT;
                    end
                    else
                    begin
                        state_next = bals_pkg::S_EV_PRE;
                    end
                end
            bals_pkg::S_EV_PRE:
                if (ev_sub_reg == 3'd2)
                begin
                    state_next = bals_pkg::S_EV_MAC;
                end
            bals_pkg::S_EV_MAC:
                if (ev_k_reg == 2'd3 && ev_sub_reg == 3'd4)
                begin
                    state_next = bals_pkg::S_EV_FIN;
                end
            bals_pkg::S_EV_FIN:
                state_next = (phase_reg == bals_pkg::PH_TABLE) ? bals_pkg::S_TB_SQ
                                                               : bals_pkg::S_EMIT;
            bals_pkg::S_EMIT:
                if (pt_reg == d_reg)
                begin
                    state_next = bals_pkg::S_IDLE;
                end
                else
                begin
                    state_next = (phase_reg == bals_pkg::PH_COUNT) ? bals_pkg::S_CT_SETUP
                                                                   : bals_pkg::S_MT_TGT;
                end
            bals_pkg::S_TB_INIT:  state_next = bals_pkg::S_EV_PRE;
            bals_pkg::S_TB_SQ:
                if (ev_sub_reg == 3'd1)
                begin
                    state_next = bals_pkg::S_SQRT;
                end
            bals_pkg::S_SQRT:
                if (sq_bit_reg == bals_pkg::SQ_W'(1))
                begin
                    state_next = bals_pkg::S_TB_ACC;
                end
            bals_pkg::S_TB_ACC:
                state_next = (tb_i_reg == bals_pkg::SEG_W'(bals_pkg::SEGMENTS))
                           ? bals_pkg::S_LEN : bals_pkg::S_EV_PRE;
            bals_pkg::S_LEN:      state_next = bals_pkg::S_DIV;
            bals_pkg::S_MT_TGT:   state_next = bals_pkg::S_BS_CHK;
            bals_pkg::S_BS_CHK:
                state_next = (lo_reg < hi_reg) ? bals_pkg::S_BS_WAIT : bals_pkg::S_K_RD;
            bals_pkg::S_BS_WAIT:  state_next = bals_pkg::S_BS_CMP;
            bals_pkg::S_BS_CMP:   state_next = bals_pkg::S_BS_CHK;
            bals_pkg::S_K_RD:     state_next = bals_pkg::S_K_MUL;
            bals_pkg::S_K_MUL:    state_next = bals_pkg::S_K_CHK;
            bals_pkg::S_K_CHK:
                if (ekd_reg > target_reg && k_reg != '0 && !kdec_reg)
                begin
                    state_next = bals_pkg::S_K_RD;
                end
                else if (ekd_reg >= target_reg
                         || k_reg >= bals_pkg::SEG_W'(bals_pkg::SEGMENTS))
                begin
                    state_next = bals_pkg::S_EV_PRE;
                end
                else
                begin
                    state_next = bals_pkg::S_K1_WAIT;
                end
            bals_pkg::S_K1_WAIT:  state_next = bals_pkg::S_DIFF;
            bals_pkg::S_DIFF:
                state_next = (diff_reg == '0) ? bals_pkg::S_EV_PRE : bals_pkg::S_KDD;
            bals_pkg::S_KDD:      state_next = bals_pkg::S_MT_DIV;
            bals_pkg::S_MT_DIV:   state_next = bals_pkg::S_DIV;
            default:              state_next = bals_pkg::S_IDLE;
        endcase
    end

    // multiplier operands and table port controls
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            bals_pkg::S_EV_PRE:
                case (ev_sub_reg)
                    3'd0:
                    begin
                        mul_a = bals_pkg::MUL_A_W'(u_val);
                        mul_b = bals_pkg::MUL_B_W'(u_val);
                    end
                    3'd1:
                    begin
                        mul_a = bals_pkg::MUL_A_W'(t_reg);
                        mul_b = bals_pkg::MUL_B_W'(t_reg);
                    end
                    default:
                    begin
                        mul_a = bals_pkg::MUL_A_W'(u_val);
                        mul_b = bals_pkg::MUL_B_W'(t_reg);
                    end
                endcase
            bals_pkg::S_EV_MAC:
                case (ev_sub_reg)
                    3'd0:
                        case (ev_k_reg)
                            2'd0:
                            begin
                                mul_a = uu_reg;
                                mul_b = bals_pkg::MUL_B_W'(u_val);
                            end
                            2'd1:
                            begin
                                mul_a = ut_reg;
                                mul_b = bals_pkg::MUL_B_W'(u_val) * bals_pkg::MUL_B_W'(3);
                            end
                            2'd2:
                            begin
                                mul_a = ut_reg;
                                mul_b = bals_pkg::MUL_B_W'(t_reg) * bals_pkg::MUL_B_W'(3);
                            end
                            default:
                            begin
                                mul_a = tt_reg;
                                mul_b = bals_pkg::MUL_B_W'(t_reg);
                            end
                        endcase
                    3'd1:
                    begin
                        mul_a = bals_pkg::MUL_A_W'(w_reg[bals_pkg::W_LO_W-1:0]);
                        mul_b = bals_pkg::MUL_B_W'(bx_reg[ev_k_reg]);
                    end
                    3'd2:
                    begin
                        mul_a = bals_pkg::MUL_A_W'(w_reg[bals_pkg::W_W-1:bals_pkg::W_LO_W]);
                        mul_b = bals_pkg::MUL_B_W'(bx_reg[ev_k_reg]);
                    end
                    3'd3:
                    begin
                        mul_a = bals_pkg::MUL_A_W'(w_reg[bals_pkg::W_LO_W-1:0]);
                        mul_b = bals_pkg::MUL_B_W'(by_reg[ev_k_reg]);
                    end
                    default:
                    begin
                        mul_a = bals_pkg::MUL_A_W'(w_reg[bals_pkg::W_W-1:bals_pkg::W_LO_W]);
                        mul_b = bals_pkg::MUL_B_W'(by_reg[ev_k_reg]);
                    end
                endcase
            bals_pkg::S_TB_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '0;
            end
            bals_pkg::S_TB_SQ:
                if (ev_sub_reg == 3'd0)
                begin
                    mul_a = bals_pkg::MUL_A_W'(dx_val);
                    mul_b = bals_pkg::MUL_B_W'(dx_val);
                end
                else
                begin
                    mul_a = bals_pkg::MUL_A_W'(dy_val);
                    mul_b = bals_pkg::MUL_B_W'(dy_val);
                end
            bals_pkg::S_TB_ACC:
            begin
                ram_we    = 1'b1;
                ram_waddr = tb_i_reg;
                ram_wdata = acc_sat;
            end
            bals_pkg::S_MT_TGT:
            begin
                mul_a = bals_pkg::MUL_A_W'(acc_reg);
                mul_b = bals_pkg::MUL_B_W'(pt_reg);
            end
            bals_pkg::S_BS_CHK:
            begin
                ram_re    = lo_reg < hi_reg;
                ram_raddr = mid_sum[bals_pkg::SEG_W:1];
            end
            bals_pkg::S_BS_WAIT, bals_pkg::S_K_MUL:
            begin
                mul_a = bals_pkg::MUL_A_W'(ram_rdata);
                mul_b = bals_pkg::MUL_B_W'(d_reg);
            end
            bals_pkg::S_K_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = k_reg;
            end
            bals_pkg::S_K_CHK:
            begin
                ram_re    = (state_next == bals_pkg::S_K1_WAIT);
                ram_raddr = k_reg + bals_pkg::SEG_W'(1);
            end
            bals_pkg::S_DIFF:
            begin
                mul_a = bals_pkg::MUL_A_W'(diff_reg);
                mul_b = bals_pkg::MUL_B_W'(d_reg);
            end
            bals_pkg::S_KDD:
            begin
                mul_a = bals_pkg::MUL_A_W'(dd_reg);
                mul_b = bals_pkg::MUL_B_W'(k_reg);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bals_pkg::S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == bals_pkg::S_EMIT)
                       || (state_reg == bals_pkg::S_INVALID);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            bals_pkg::S_IDLE:
                if (start)
                begin
                    action_reg <= action;
                    pc_reg     <= point_count;
                    sp_reg     <= spacing;
                    bx_reg[0]  <= p0_x ^ 16'h8000;
                    by_reg[0]  <= p0_y ^ 16'h8000;
                    bx_reg[1]  <= p1_x ^ 16'h8000;
                    by_reg[1]  <= p1_y ^ 16'h8000;
                    bx_reg[2]  <= p2_x ^ 16'h8000;
                    by_reg[2]  <= p2_y ^ 16'h8000;
                    bx_reg[3]  <= p3_x ^ 16'h8000;
                    by_reg[3]  <= p3_y ^ 16'h8000;
                end
            bals_pkg::S_CHECK:
            begin
                pt_reg     <= '0;
                ev_sub_reg <= '0;
                phase_reg  <= action_reg ? bals_pkg::PH_TABLE : bals_pkg::PH_COUNT;
                if (pc_reg > bals_pkg::CNT_W'(bals_pkg::MAX_POINTS))
                begin
                    d_reg    <= bals_pkg::IDX_W'(bals_pkg::MAX_POINTS - 1);
                    clip_reg <= 1'b1;
                end
                else
                begin
                    d_reg    <= bals_pkg::IDX_W'(pc_reg - bals_pkg::CNT_W'(1));
                    clip_reg <= 1'b0;
                end
            end
            bals_pkg::S_INVALID:
            begin
                out_x_reg    <= '0;
                out_y_reg    <= '0;
                out_idx_reg  <= '0;
                out_last_reg <= 1'b1;
                out_st_reg   <= bals_pkg::ST_INVALID;
            end
            // t = (i * one + d/2) / d
            bals_pkg::S_CT_SETUP:
            begin
                dv_rem_reg <= (bals_pkg::DIV_W'(pt_reg) << bals_pkg::T_FRAC)
                            + bals_pkg::DIV_W'(d_reg >> 1);
                dv_sh_reg  <= bals_pkg::DIV_W'(d_reg) << (bals_pkg::QUO_W - 1);
                dv_q_reg   <= '0;
                dv_cnt_reg <= bals_pkg::DCNT_W'(bals_pkg::QUO_W - 1);
            end
            // restoring divider, one quotient bit per cycle
            bals_pkg::S_DIV:
            begin
                if (dv_ge)
                begin
                    dv_rem_reg <= dv_rem_reg - dv_sh_reg;
                end
                dv_sh_reg  <= dv_sh_reg >> 1;
                dv_q_reg   <= q_next;
                dv_cnt_reg <= dv_cnt_reg - bals_pkg::DCNT_W'(1);
                if (dv_cnt_reg == '0)
                begin
                    t_reg <= q_next;
                    if (phase_reg == bals_pkg::PH_LEN)
                    begin
                        phase_reg <= bals_pkg::PH_SPACE;
                        pt_reg    <= '0;
                        if (q_next > bals_pkg::QUO_W'(bals_pkg::MAX_POINTS))
                        begin
                            d_reg    <= bals_pkg::IDX_W'(bals_pkg::MAX_POINTS - 1);
                            clip_reg <= 1'b1;
                        end
                        else
                        begin
                            d_reg    <= bals_pkg::IDX_W'(q_next - bals_pkg::QUO_W'(1));
                            clip_reg <= 1'b0;
                        end
                    end
                end
            end
            // curve evaluation: products of t and 1-t
            bals_pkg::S_EV_PRE:
            begin
                case (ev_sub_reg)
                    3'd0:    uu_reg <= prod[bals_pkg::MUL_A_W-1:0];
                    3'd1:    tt_reg <= prod[bals_pkg::MUL_A_W-1:0];
                    default: ut_reg <= prod[bals_pkg::MUL_A_W-1:0];
                endcase
                ev_sub_reg <= (ev_sub_reg == 3'd2) ? 3'd0 : ev_sub_reg + 3'd1;
                ev_k_reg   <= '0;
                ax_reg     <= '0;
                ay_reg     <= '0;
            end
            // weight, then weight times coordinate in two halves
            bals_pkg::S_EV_MAC:
            begin
                case (ev_sub_reg)
                    3'd0:    w_reg  <= prod[bals_pkg::W_W-1:0];
                    3'd1:    ax_reg <= ax_reg + bals_pkg::ACC_W'(prod);
                    3'd2:    ax_reg <= ax_reg + (bals_pkg::ACC_W'(prod) << bals_pkg::W_LO_W);
                    3'd3:    ay_reg <= ay_reg + bals_pkg::ACC_W'(prod);
                    default: ay_reg <= ay_reg + (bals_pkg::ACC_W'(prod) << bals_pkg::W_LO_W);
                endcase
                if (ev_sub_reg == 3'd4)
                begin
                    ev_sub_reg <= '0;
                    ev_k_reg   <= ev_k_reg + 2'd1;
                end
                else
                begin
                    ev_sub_reg <= ev_sub_reg + 3'd1;
                end
            end
            bals_pkg::S_EV_FIN:
            begin
                cx_reg     <= ax_rnd[bals_pkg::RND_POS +: bals_pkg::COORD_W];
                cy_reg     <= ay_rnd[bals_pkg::RND_POS +: bals_pkg::COORD_W];
                ev_sub_reg <= '0;
            end
            bals_pkg::S_EMIT:
            begin
                out_x_reg    <= cx_reg ^ 16'h8000;
                out_y_reg    <= cy_reg ^ 16'h8000;
                out_idx_reg  <= pt_reg;
                out_last_reg <= pt_reg == d_reg;
                out_st_reg   <= clip_reg ? bals_pkg::ST_CLIPPED : bals_pkg::ST_OK;
                pt_reg       <= pt_reg + bals_pkg::IDX_W'(1);
            end
            // table start: sample 0 is the start point
            bals_pkg::S_TB_INIT:
            begin
                acc_reg  <= '0;
                px_reg   <= bx_reg[0];
                py_reg   <= by_reg[0];
                tb_i_reg <= bals_pkg::SEG_W'(1);
                t_reg    <= bals_pkg::seg_t(bals_pkg::SEG_W'(1));
            end
            // squared chord; the step count returns to zero for the next evaluation
            bals_pkg::S_TB_SQ:
            begin
                ev_sub_reg <= (ev_sub_reg == 3'd1) ? 3'd0 : ev_sub_reg + 3'd1;
                if (ev_sub_reg == 3'd0)
                begin
                    sqv_reg <= prod[bals_pkg::SQ_W-1:0];
                end
                else
                begin
                    sq_x_reg   <= sqv_reg + prod[bals_pkg::SQ_W-1:0];
                    sq_r_reg   <= '0;
                    sq_bit_reg <= bals_pkg::SQ_W'(1) << (bals_pkg::SQ_W - 2);
                end
            end
            // digit-by-digit square root, one root bit per cycle
            bals_pkg::S_SQRT:
            begin
                if (sq_x_reg >= sq_trial)
                begin
                    sq_x_reg <= sq_x_reg - sq_trial;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            bals_pkg::S_TB_ACC:
            begin
                acc_reg  <= acc_sat;
                px_reg   <= cx_reg;
                py_reg   <= cy_reg;
                tb_i_reg <= tb_i_reg + bals_pkg::SEG_W'(1);
                t_reg    <= bals_pkg::seg_t(tb_i_reg + bals_pkg::SEG_W'(1));
            end
            // point count = length / spacing
            bals_pkg::S_LEN:
            begin
                phase_reg  <= bals_pkg::PH_LEN;
                dv_rem_reg <= bals_pkg::DIV_W'(acc_reg);
                dv_sh_reg  <= bals_pkg::DIV_W'(sp_reg) << (bals_pkg::QUO_W - 1);
                dv_q_reg   <= '0;
                dv_cnt_reg <= bals_pkg::DCNT_W'(bals_pkg::QUO_W - 1);
            end
            // arc-length target i * L, compared against table * d
            bals_pkg::S_MT_TGT:
            begin
                target_reg <= prod[bals_pkg::TGT_W-1:0];
                lo_reg     <= '0;
                hi_reg     <= bals_pkg::SEG_W'(bals_pkg::SEGMENTS);
                kdec_reg   <= 1'b0;
            end
            bals_pkg::S_BS_CHK:
                k_reg <= (lo_reg < hi_reg) ? mid_sum[bals_pkg::SEG_W:1] : lo_reg;
            bals_pkg::S_BS_WAIT:
                ekd_reg <= prod[bals_pkg::TGT_W-1:0];
            bals_pkg::S_BS_CMP:
                if (ekd_reg < target_reg)
                begin
                    lo_reg <= k_reg + bals_pkg::SEG_W'(1);
                end
                else
                begin
                    hi_reg <= k_reg;
                end
            bals_pkg::S_K_MUL:
            begin
                ek_reg  <= ram_rdata;
                ekd_reg <= prod[bals_pkg::TGT_W-1:0];
            end
            bals_pkg::S_K_CHK:
                if (ekd_reg > target_reg && k_reg != '0 && !kdec_reg)
                begin
                    k_reg    <= k_reg - bals_pkg::SEG_W'(1);
                    kdec_reg <= 1'b1;
                end
                else if (ekd_reg >= target_reg
                         || k_reg >= bals_pkg::SEG_W'(bals_pkg::SEGMENTS))
                begin
                    t_reg <= bals_pkg::seg_t(k_reg);
                end
                else
                begin
                    rem_reg <= target_reg - ekd_reg;
                end
            bals_pkg::S_K1_WAIT:
                diff_reg <= ram_rdata - ek_reg;
            bals_pkg::S_DIFF:
                if (diff_reg == '0)
                begin
                    t_reg <= bals_pkg::seg_t(k_reg);
                end
                else
                begin
                    dd_reg <= prod[bals_pkg::DD_W-1:0];
                end
            bals_pkg::S_KDD:
                kdd_reg <= prod[bals_pkg::KDD_W-1:0];
            // interpolated t = (k*d*diff + rem) * one / (SEGMENTS*d*diff), rounded
            bals_pkg::S_MT_DIV:
            begin
                dv_rem_reg <= ((bals_pkg::DIV_W'(kdd_reg) + bals_pkg::DIV_W'(rem_reg))
                               << bals_pkg::T_FRAC)
                            + bals_pkg::DIV_W'(dd_reg) * bals_pkg::DIV_W'(bals_pkg::SEGMENTS / 2);
                dv_sh_reg  <= (bals_pkg::DIV_W'(dd_reg) * bals_pkg::DIV_W'(bals_pkg::SEGMENTS))
                              << (bals_pkg::QUO_W - 1);
                dv_q_reg   <= '0;
                dv_cnt_reg <= bals_pkg::DCNT_W'(bals_pkg::QUO_W - 1);
            end
            default:
            begin
                dv_q_reg <= dv_q_reg;
            end
        endcase
    end

    assign busy        = state_reg != bals_pkg::S_IDLE;
    assign strobe      = strobe_reg;
    assign point_x     = out_x_reg;
    assign point_y     = out_y_reg;
    assign point_index = out_idx_reg;
    assign last        = out_last_reg;
    assign status      = out_st_reg;

    // a result always follows a cycle of work
    assert property (@(posedge clk) disable iff (!rst_n) strobe |-> $past(busy))
        else $error("result without a request in progress");

    // a taken request keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // an invalid answer is a single final result
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status == bals_pkg::ST_INVALID) |-> (last && point_index == '0))
        else $error("invalid result not a single final result");

    // table is never read while being written
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
        else $error("length table read and written together");

    // the run ends after its last point
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> (state_reg == bals_pkg::S_IDLE || state_reg == bals_pkg::S_CHECK))
        else $error("last result issued while run continues");

endmodule

// File: sim/testbench.sv
// Testbench of bezier_arc_length_sampler: directed and random requests in count and
// spacing mode, checked point by point against an in-bench predictor of the sampler.
// Depends on bals_pkg and the RTL of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [5:0]         index;
        logic               last;
        logic [1:0]         status;
    } curve_point_t;

    // Expected points and mismatch tally
    class point_scoreboard;
        curve_point_t pending[$];
        int unsigned  errors;
        int unsigned  seen;
        logic [63:0]  bias_x[4];
        logic [63:0]  bias_y[4];
        logic [19:0]  chord_sum[bals_pkg::SEGMENTS+1];

        function void curve_at(input logic [63:0] t, output logic [15:0] ox,
                               output logic [15:0] oy);
            logic [63:0] u;
            logic [63:0] w[4];
            logic [63:0] ax;
            logic [63:0] ay;
            u = 64'(bals_pkg::T_ONE) - t;
            w[0] = u * u * u;
            w[1] = 3 * u * u * t;
            w[2] = 3 * u * t * t;
            w[3] = t * t * t;
            ax = 0;
            ay = 0;
            for (int k = 0; k < 4; k++)
            begin
                ax += w[k] * bias_x[k];
                ay += w[k] * bias_y[k];
            end
            ox = 16'((ax + (64'd1 << 47)) >> 48) ^ 16'h8000;
            oy = 16'((ay + (64'd1 << 47)) >> 48) ^ 16'h8000;
        endfunction

        function logic [63:0] nearest_root(input logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            logic [63:0] x;
            r = 0;
            b = 64'd1 << 62;
            x = v;
            while (b > x) b >>= 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            if (v - r * r > r) r++;
            return r;
        endfunction

        function logic [63:0] seg_param(input logic [63:0] k);
            return (k * bals_pkg::T_ONE + bals_pkg::SEGMENTS / 2) / bals_pkg::SEGMENTS;
        endfunction

        // t at arc length i*L/d, search plus interpolation
        function logic [63:0] arc_to_t(input logic [63:0] i, input logic [63:0] d);
            logic [63:0] goal;
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] k;
            logic [63:0] rem;
            logic [63:0] diff;
            logic [63:0] num;
            logic [63:0] den;
            goal = i * chord_sum[bals_pkg::SEGMENTS];
            lo = 0;
            hi = bals_pkg::SEGMENTS;
            while (lo < hi)
            begin
                k = lo + (hi - lo) / 2;
                if (64'(chord_sum[k]) * d < goal) lo = k + 1;
                else hi = k;
            end
            k = lo;
            if (64'(chord_sum[k]) * d > goal && k > 0) k--;
            if (64'(chord_sum[k]) * d >= goal || k >= bals_pkg::SEGMENTS)
                return seg_param(k);
            rem = goal - 64'(chord_sum[k]) * d;
            diff = 64'(chord_sum[k+1]) - 64'(chord_sum[k]);
            if (diff == 0) return seg_param(k);
            den = bals_pkg::SEGMENTS * d * diff;
            num = (k * d * diff + rem) * bals_pkg::T_ONE;
            return (num + den / 2) / den;
        endfunction

        function void push(input logic [15:0] x, input logic [15:0] y, input int i,
                           input logic lst, input logic [1:0] st);
            curve_point_t p;
            p.x = x;
            p.y = y;
            p.index = 6'(i);
            p.last = lst;
            p.status = st;
            pending = {pending, p};
        endfunction

        // Accepted request: predict its whole run
        function void note_request(input logic act, input logic [15:0] pts[8],
                                   input logic [6:0] cnt, input logic [15:0] sp);
            logic [63:0] n;
            logic [63:0] d;
            logic [63:0] acc;
            logic [63:0] dx;
            logic [63:0] dy;
            logic [15:0] px;
            logic [15:0] py;
            logic [15:0] cx;
            logic [15:0] cy;
            logic [1:0]  st;
            st = bals_pkg::ST_OK;
            for (int k = 0; k < 4; k++)
            begin
                bias_x[k] = 64'(pts[2*k] ^ 16'h8000);
                bias_y[k] = 64'(pts[2*k+1] ^ 16'h8000);
            end
            if (!act)
                n = cnt;
            else if (sp < bals_pkg::SP_MIN)
                n = 0;
            else
            begin
                chord_sum[0] = 0;
                acc = 0;
                curve_at(0, px, py);
                for (int i = 1; i <= bals_pkg::SEGMENTS; i++)
                begin
                    curve_at(seg_param(i), cx, cy);
                    dx = 64'(cx ^ 16'h8000);
                    dy = 64'(px ^ 16'h8000);
                    dx = dx > dy ? dx - dy : dy - dx;
                    dy = 64'(cy ^ 16'h8000) > 64'(py ^ 16'h8000) ?
                         64'(cy ^ 16'h8000) - 64'(py ^ 16'h8000) :
                         64'(py ^ 16'h8000) - 64'(cy ^ 16'h8000);
                    acc += nearest_root(dx * dx + dy * dy);
                    if (acc > bals_pkg::LEN_MAX) acc = bals_pkg::LEN_MAX;
                    chord_sum[i] = 20'(acc);
                    px = cx;
                    py = cy;
                end
                n = chord_sum[bals_pkg::SEGMENTS] / sp;
            end
            if (n < 2)
            begin
                push(16'h0, 16'h0, 0, 1'b1, bals_pkg::ST_INVALID);
                return;
            end
            if (n > bals_pkg::MAX_POINTS)
            begin
                n = bals_pkg::MAX_POINTS;
                st = bals_pkg::ST_CLIPPED;
            end
            d = n - 1;
            for (int i = 0; i < n; i++)
            begin
                if (!act) curve_at((64'(i) * bals_pkg::T_ONE + d / 2) / d, cx, cy);
                else curve_at(arc_to_t(i, d), cx, cy);
                push(cx, cy, i, 64'(i) == d, st);
            end
        endfunction

        function void check_point(input curve_point_t got);
            curve_point_t want;
            seen++;
            if (pending.size() == 0)
            begin
                $error("unexpected point x=%0d y=%0d index=%0d", got.x, got.y, got.index);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x)
            begin
                $error("point_x: expected %0d, got %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y)
            begin
                $error("point_y: expected %0d, got %0d", want.y, got.y);
                errors++;
            end
            if (got.index !== want.index)
            begin
                $error("point_index: expected %0d, got %0d", want.index, got.index);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 40000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic action;
    logic signed [15:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
    logic [6:0]  point_count;
    logic [15:0] spacing;
    logic        strobe;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [5:0]  point_index;
    logic        last;
    logic [1:0]  status;

    point_scoreboard board;
    int unsigned requests;
    int unsigned idle_cycles;
    int unsigned spacing_runs;

    bezier_arc_length_sampler dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive one request and hold it until the transfer; start drops only during a gap
    task automatic send_request(input logic act, input logic [15:0] pts[8],
                                input logic [6:0] cnt, input logic [15:0] sp);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action <= act;
        {p0_x, p0_y, p1_x, p1_y} <= {pts[0], pts[1], pts[2], pts[3]};
        {p2_x, p2_y, p3_x, p3_y} <= {pts[4], pts[5], pts[6], pts[7]};
        point_count <= cnt;
        spacing <= sp;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        board.note_request(act, pts, cnt, sp);
        requests++;
        if (act) spacing_runs++;
        @(negedge clk);
    endtask

    task automatic random_points(output logic [15:0] pts[8], input int span);
        for (int k = 0; k < 8; k++)
            pts[k] = span >= 32768 ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // Result capture
    always @(posedge clk)
    begin
        curve_point_t got;
        if (rst_n && strobe)
        begin
            got.x = point_x;
            got.y = point_y;
            got.index = point_index;
            got.last = last;
            got.status = status;
            board.check_point(got);
        end
    end

    // Watchdog on cycles with no transfer either way
    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] pts[8];
        logic [15:0] corner[8];
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        action = 1'b0;
        {p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y} = '0;
        point_count = '0;
        spacing = '0;
        requests = 0;
        spacing_runs = 0;
        idle_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: counts at the edges, invalid and clipped cases, extreme points
        corner = '{16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                   16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        send_request(1'b0, corner, 7'd0, 16'd0);
        send_request(1'b0, corner, 7'd1, 16'hFFFF);
        send_request(1'b0, corner, 7'd2, 16'd0);
        send_request(1'b0, corner, 7'd64, 16'd0);
        send_request(1'b0, corner, 7'd65, 16'd0);
        send_request(1'b0, corner, 7'd127, 16'd0);
        pts = '{default: 16'h7FFF};
        send_request(1'b0, pts, 7'd3, 16'd0);
        send_request(1'b1, pts, 7'd3, 16'd16);
        random_points(pts, 4000);
        send_request(1'b1, pts, 7'd0, 16'd15);
        send_request(1'b1, pts, 7'd0, 16'd0);
        send_request(1'b1, pts, 7'd0, 16'hFFFF);
        send_request(1'b1, corner, 7'h7F, 16'd16);
        send_request(1'b1, corner, 7'd0, 16'd4000);
        pts = '{16'd0, 16'd0, 16'd160, 16'd0, 16'd320, 16'd0, 16'd480, 16'd0};
        send_request(1'b1, pts, 7'd5, 16'd16);
        send_request(1'b1, pts, 7'd5, 16'd48);
        wait_drained();

        // Random: mostly count mode, spacing mode with sizes that give real runs
        for (int r = 0; r < 100; r++)
        begin
            random_points(pts, $urandom_range(0, 3) == 0 ? 32768 : 2000);
            if ($urandom_range(0, 2) != 0)
                send_request(1'b0, pts, $urandom_range(0, 5) == 0 ?
                             7'($urandom) : 7'($urandom_range(2, 20)), 16'($urandom));
            else
                send_request(1'b1, pts, 7'($urandom), $urandom_range(0, 7) == 0 ?
                             16'($urandom) : 16'($urandom_range(16, 600)));
            if (r == 50) wait_drained();
        end

        wait_drained();
        repeat (100) @(posedge clk);
        $display("Covered %0d requests (%0d by spacing) and %0d points.",
                 requests, spacing_runs, board.seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: bezier_arc_length_sampler.f
sv/bals_pkg.sv
sv/bals_ram.sv
sv/bezier_arc_length_sampler.sv
sim/testbench.sv
